// ----- rtl/u2c_pkg.sv -----
package u2c_pkg;

   // Default width of the running UTF-16 offset counter
   localparam int OFFSET_BITS_DEFAULT = 32;

   localparam int BYTE_W     = 8;
   localparam int CP_W       = 21;
   localparam int POS_W      = 32;
   localparam int UNITS_W    = 2;
   localparam int COUNT_W    = 3;
   localparam int REMAIN_W   = 2;

   // Lead byte payload masks
   localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'h1F;
   localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'h0F;
   localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'h07;
   localparam logic [BYTE_W-1:0] CONT_MASK  = 8'h3F;

   localparam logic [UNITS_W-1:0] UNITS_ONE = 2'd1;
   localparam logic [UNITS_W-1:0] UNITS_TWO = 2'd2;

   localparam logic [COUNT_W-1:0] LEN_ONE   = 3'd1;
   localparam logic [COUNT_W-1:0] LEN_TWO   = 3'd2;
   localparam logic [COUNT_W-1:0] LEN_THREE = 3'd3;
   localparam logic [COUNT_W-1:0] LEN_FOUR  = 3'd4;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              last_of_text;
   } req_payload_type;

   typedef struct packed {
      logic [CP_W-1:0]    code_point;
      logic [POS_W-1:0]   utf16_position;
      logic [UNITS_W-1:0] utf16_units;
      logic [COUNT_W-1:0] byte_count;
      logic               truncated;
   } rsp_payload_type;

endpackage

// ----- rtl/u2c_stream_if.sv -----
interface u2c_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/u2c_input_stage.sv -----
module u2c_input_stage (
   input  logic                     clock,
   input  logic                     reset,
   u2c_stream_if.sink               req_if,
   input  logic                     drain,
   output logic                     beat_valid,
   output u2c_pkg::req_payload_type beat
);
   import u2c_pkg::*;

   logic            valid_ff;
   req_payload_type beat_ff;
   logic            take;

   // Accept when empty or when the held beat moves on this cycle
   assign req_if.ready = !valid_ff || drain;
   assign take         = req_if.valid && req_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         beat_ff <= req_if.payload;
      end
   end

   assign beat_valid = valid_ff;
   assign beat       = beat_ff;
endmodule

// ----- rtl/u2c_decode.sv -----
module u2c_decode #(
   parameter int OFFSET_BITS = u2c_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  u2c_pkg::req_payload_type beat,
   output logic                     emit,
   output u2c_pkg::rsp_payload_type result
);
   import u2c_pkg::*;

   localparam int EXT_W = (OFFSET_BITS > POS_W) ? OFFSET_BITS : POS_W;

   logic [CP_W-1:0]        pv_ff, pv_in;
   logic [REMAIN_W-1:0]    rem_ff, rem_in;
   logic [COUNT_W-1:0]     len_ff, len_in;
   logic [OFFSET_BITS-1:0] cnt_ff, cnt_in;

   logic [BYTE_W-1:0]      b;
   logic                   last;
   logic [CP_W-1:0]        cont;
   logic [CP_W-1:0]        cont_sh;
   logic [CP_W-1:0]        cp;
   logic [COUNT_W-1:0]     nbytes;
   logic                   trunc;
   logic [UNITS_W-1:0]     units;
   logic [EXT_W-1:0]       pos_ext;

   assign b    = beat.data_byte;
   assign last = beat.last_of_text;
   assign cont = CP_W'(b & CONT_MASK);

   always_comb begin
      unique case (rem_ff)
         2'd2:    cont_sh = cont << 6;
         2'd3:    cont_sh = cont << 12;
         default: cont_sh = cont;
      endcase
   end

   always_comb begin
      pv_in  = pv_ff;
      rem_in = rem_ff;
      len_in = len_ff;
      emit   = 1'b0;
      cp     = '0;
      nbytes = LEN_ONE;
      trunc  = 1'b0;

      if (rem_ff == '0) begin
         priority if (!b[7] || b[7:6] == 2'b10) begin
            // ASCII or stray continuation byte stands for itself
            emit = 1'b1;
            cp   = CP_W'(b);
         end else if (b[7:5] == 3'b110) begin
            pv_in  = CP_W'(b & LEAD2_MASK) << 6;
            rem_in = 2'd1;
            len_in = LEN_TWO;
         end else if (b[7:4] == 4'b1110) begin
            pv_in  = CP_W'(b & LEAD3_MASK) << 12;
            rem_in = 2'd2;
            len_in = LEN_THREE;
         end else begin
            pv_in  = CP_W'(b & LEAD4_MASK) << 18;
            rem_in = 2'd3;
            len_in = LEN_FOUR;
         end
         if (!emit && last) begin
            emit  = 1'b1;
            cp    = pv_in;
            trunc = 1'b1;
         end
      end else begin
         pv_in  = pv_ff | cont_sh;
         rem_in = rem_ff - 2'd1;
         if (rem_in == '0) begin
            emit   = 1'b1;
            cp     = pv_in;
            nbytes = len_ff;
         end else if (last) begin
            emit   = 1'b1;
            cp     = pv_in;
            nbytes = len_ff - {1'b0, rem_in};
            trunc  = 1'b1;
         end
      end

      units = (cp[CP_W-1:16] != '0) ? UNITS_TWO : UNITS_ONE;

      cnt_in = cnt_ff;
      if (emit) begin
         cnt_in = cnt_ff + OFFSET_BITS'(units);
      end
      if (emit && rem_in == '0) begin
         pv_in  = '0;
         len_in = '0;
      end
      if (last) begin
         pv_in  = '0;
         rem_in = '0;
         len_in = '0;
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff  <= '0;
         rem_ff <= '0;
         len_ff <= '0;
         cnt_ff <= '0;
      end else if (step) begin
         pv_ff  <= pv_in;
         rem_ff <= rem_in;
         len_ff <= len_in;
         cnt_ff <= cnt_in;
      end
   end

   // Position is taken before the counter advances
   assign pos_ext = EXT_W'(cnt_ff);

   assign result.code_point     = cp;
   assign result.utf16_position = pos_ext[POS_W-1:0];
   assign result.utf16_units    = units;
   assign result.byte_count     = nbytes;
   assign result.truncated      = trunc;
endmodule

// ----- rtl/utf8_to_codepoint_utf16_offset_core.sv -----
// An accepted req beat passes through the input register and then the result register to become its rsp beat.
// Throughput: one byte per cycle, sustained, with no stall on the rsp side.
// Bytes that only open or extend a sequence produce no rsp beat.
// Reset (synchronous, active high) empties both registers, drops any partial
// character and clears the UTF-16 offset counter.
module utf8_to_codepoint_utf16_offset_core #(
   parameter int OFFSET_BITS = u2c_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   u2c_stream_if.sink   req_if,
   u2c_stream_if.source rsp_if
);
   import u2c_pkg::*;

   // Input register holds one byte beat
   logic            beat_valid;
   req_payload_type beat;

   // Decode results for the held beat
   logic            emit;
   rsp_payload_type result;

   // Result register
   logic            rsp_valid_ff;
   rsp_payload_type rsp_payload_ff;

   logic            out_free;
   logic            step;

   // The result register can load when empty or when its beat leaves now
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   // Advance the held byte through the decoder
   assign step     = beat_valid && out_free;

   u2c_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .drain      (out_free),
      .beat_valid (beat_valid),
      .beat       (beat)
   );

   u2c_decode #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_decode (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .beat   (beat),
      .emit   (emit),
      .result (result)
   );

   // Load a new result or drop the delivered one
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= step && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (step && emit) begin
         rsp_payload_ff <= result;
      end
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_payload_ff;

`ifndef NO_ASSERTIONS
   // A complete single-byte character is ASCII or a stray continuation byte
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_payload_ff.truncated && rsp_payload_ff.byte_count == LEN_ONE)
      |-> (rsp_payload_ff.code_point < CP_W'(8'hC0)))
      else $error("single-byte result out of range");

   // A cut-off character never carries a full four bytes
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_payload_ff.truncated)
      |-> (rsp_payload_ff.byte_count >= LEN_ONE && rsp_payload_ff.byte_count <= LEN_THREE))
      else $error("truncated result with bad byte count");

   // A held byte that cannot advance stays in the input register
   assert property (@(posedge clock) disable iff (reset)
      (beat_valid && !out_free) |=> (beat_valid && $stable(beat)))
      else $error("held byte lost while stalled");
`endif

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import u2c_pkg::*;

   localparam int OFFSET_W = OFFSET_BITS_DEFAULT;
   // Quiet cycles tolerated before the run is declared hung.
   localparam int HANG_LIMIT = 2000;
   localparam logic [CP_W-1:0] SUPPLEMENTARY_BASE = 21'h1_0000;

   logic clock = 1'b0;
   logic reset;

   u2c_stream_if #(.payload_type(req_payload_type)) req_ch ();
   u2c_stream_if #(.payload_type(rsp_payload_type)) rsp_ch ();

   utf8_to_codepoint_utf16_offset_core #(
      .OFFSET_BITS(OFFSET_W)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_if(req_ch),
      .rsp_if(rsp_ch)
   );

   always #6 clock = ~clock;

   // Bytes waiting to go out, and decoded characters waiting to come back.
   req_payload_type pending_bytes[$];
   rsp_payload_type expected_chars[$];

   // Shadow decoder state, updated once per accepted req beat.
   logic [CP_W-1:0]     gathered_bits;
   logic [REMAIN_W-1:0] cont_left;
   logic [COUNT_W-1:0]  announced_len;
   logic [OFFSET_W-1:0] utf16_offset;

   int unsigned send_idle_pct;
   int unsigned stall_pct;
   int unsigned send_gap;
   int unsigned stall_left;
   bit          send_rested;
   bit          stall_rested;
   int unsigned bytes_queued;
   int unsigned quiet_cycles;
   int unsigned mismatches;

   rsp_payload_type predicted;
   rsp_payload_type observed;

   // Build one character result at the current offset, then advance the
   // offset by the UTF-16 units it occupies.
   function automatic rsp_payload_type make_char(input logic [CP_W-1:0] cp,
                                                 input logic [COUNT_W-1:0] len,
                                                 input logic cut);
      rsp_payload_type ch;
      ch.code_point     = cp;
      ch.utf16_units    = (cp >= SUPPLEMENTARY_BASE) ? UNITS_TWO : UNITS_ONE;
      ch.utf16_position = POS_W'(utf16_offset);
      ch.byte_count     = len;
      ch.truncated      = cut;
      utf16_offset      = utf16_offset + OFFSET_W'(ch.utf16_units);
      return ch;
   endfunction

   // Step the shadow decoder by one byte; return 1 when a character completes
   // (or is cut off by the end of the text).
   function automatic bit decode_byte(input req_payload_type beat,
                                      output rsp_payload_type ch);
      logic [BYTE_W-1:0] b;
      bit                emitted;
      b       = beat.data_byte;
      emitted = 1'b0;
      ch      = '0;
      if (cont_left == 0) begin
         if (!b[7] || b[7:6] == 2'b10) begin
            // ASCII, or a stray continuation byte standing for itself
            ch      = make_char(CP_W'(b), LEN_ONE, 1'b0);
            emitted = 1'b1;
         end else if (b[7:5] == 3'b110) begin
            gathered_bits = CP_W'(b & LEAD2_MASK) << 6;
            cont_left     = 2'd1;
            announced_len = LEN_TWO;
         end else if (b[7:4] == 4'b1110) begin
            gathered_bits = CP_W'(b & LEAD3_MASK) << 12;
            cont_left     = 2'd2;
            announced_len = LEN_THREE;
         end else begin
            // 0xF0..0xFF all open a 4-byte sequence
            gathered_bits = CP_W'(b & LEAD4_MASK) << 18;
            cont_left     = 2'd3;
            announced_len = LEN_FOUR;
         end
         if (!emitted && beat.last_of_text) begin
            ch      = make_char(gathered_bits, LEN_ONE, 1'b1);
            emitted = 1'b1;
         end
      end else begin
         gathered_bits = gathered_bits | (CP_W'(b & CONT_MASK) << (6 * (cont_left - 1)));
         cont_left     = cont_left - 2'd1;
         if (cont_left == 0) begin
            ch      = make_char(gathered_bits, announced_len, 1'b0);
            emitted = 1'b1;
         end else if (beat.last_of_text) begin
            ch      = make_char(gathered_bits, announced_len - COUNT_W'(cont_left), 1'b1);
            emitted = 1'b1;
         end
      end
      if (emitted && cont_left == 0) begin
         gathered_bits = '0;
         announced_len = '0;
      end
      if (beat.last_of_text) begin
         gathered_bits = '0;
         cont_left     = '0;
         announced_len = '0;
         utf16_offset  = '0;
      end
      return emitted;
   endfunction

   function automatic void compare_field(input string field, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
         mismatches++;
      end
   endfunction

   task automatic queue_byte(input logic [7:0] b, input logic last);
      req_payload_type beat;
      beat.data_byte    = b;
      beat.last_of_text = last;
      pending_bytes.push_back(beat);
      bytes_queued++;
   endtask

   // Append one complete character of random length and content.
   task automatic append_char(ref logic [7:0] text[$]);
      int unsigned len;
      len = $urandom_range(4, 1);
      case (len)
         1: text.push_back(8'($urandom_range(127)));
         2: text.push_back({3'b110, 5'($urandom)});
         3: text.push_back({4'b1110, 4'($urandom)});
         default: begin
            // mostly proper 4-byte leads, sometimes the oversized 0xF8..0xFF
            if ($urandom_range(7) == 0) text.push_back({5'b11111, 3'($urandom)});
            else text.push_back({5'b11110, 3'($urandom)});
         end
      endcase
      repeat (len - 1) text.push_back({2'b10, 6'($urandom)});
   endtask

   // Queue one text: mostly well-formed characters, some raw noise, some
   // texts that stop in the middle of a character.
   task automatic queue_random_text();
      logic [7:0]  text[$];
      int unsigned want_len;
      int unsigned style;
      want_len = $urandom_range(40, 1);
      style    = $urandom_range(99);
      while (text.size() < want_len) begin
         if (style < 15) text.push_back(8'($urandom_range(255)));
         else append_char(text);
      end
      if (style >= 82) begin
         repeat ($urandom_range(3, 1)) if (text.size() > 1) void'(text.pop_back());
      end
      foreach (text[i]) queue_byte(text[i], i == text.size() - 1);
   endtask

   // Hold until every queued beat is sent and every character is back.
   task automatic wait_for_drain();
      do @(negedge clock);
      while (pending_bytes.size() != 0 || req_ch.valid || expected_chars.size() != 0);
   endtask

   task automatic run_phase(input int unsigned idle, input int unsigned stall,
                            input int unsigned upto);
      send_idle_pct = idle;
      stall_pct     = stall;
      while (bytes_queued < upto) queue_random_text();
      wait_for_drain();
   endtask

   // Driver: present the next byte whenever the current beat has gone (or
   // none is up), unless a gap burst is running. A gap burst is never
   // followed straight by another one.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid   <= 1'b0;
         req_ch.payload <= '0;
         send_gap       <= 0;
         send_rested    <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (send_gap != 0) begin
            req_ch.valid <= 1'b0;
            send_gap     <= send_gap - 1;
         end else if (pending_bytes.size() != 0 && !send_rested &&
                      $urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            send_gap     <= $urandom_range(17, 0);
            send_rested  <= 1'b1;
         end else if (pending_bytes.size() != 0) begin
            req_ch.valid   <= 1'b1;
            req_ch.payload <= pending_bytes.pop_front();
            send_rested    <= 1'b0;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Receiver: drop ready in bursts, same pattern as above.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= 0;
         stall_rested <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else if (!stall_rested && $urandom_range(99) < stall_pct) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= $urandom_range(17, 0);
         stall_rested <= 1'b1;
      end else begin
         rsp_ch.ready <= 1'b1;
         stall_rested <= 1'b0;
      end
   end

   // Monitor: predict on every accepted req beat, check every accepted rsp
   // beat against the oldest prediction. Both in one block so the queue is
   // touched in a fixed order.
   always @(posedge clock) begin
      if (reset) begin
         gathered_bits <= '0;
         cont_left     <= '0;
         announced_len <= '0;
         utf16_offset  <= '0;
         quiet_cycles  <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            if (decode_byte(req_ch.payload, predicted)) expected_chars.push_back(predicted);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            observed = rsp_ch.payload;
            if (expected_chars.size() == 0) begin
               $error("rsp beat with nothing expected: code_point 0x%0h", observed.code_point);
               mismatches++;
            end else begin
               predicted = expected_chars.pop_front();
               compare_field("code_point", 32'(predicted.code_point), 32'(observed.code_point));
               compare_field("utf16_position", predicted.utf16_position,
                             observed.utf16_position);
               compare_field("utf16_units", 32'(predicted.utf16_units),
                             32'(observed.utf16_units));
               compare_field("byte_count", 32'(predicted.byte_count), 32'(observed.byte_count));
               compare_field("truncated", 32'(predicted.truncated), 32'(observed.truncated));
            end
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Hang detector: no beat on either side for too long.
   initial begin
      do @(negedge clock);
      while (quiet_cycles < HANG_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready   = 1'b0;
      send_idle_pct  = 20;
      stall_pct      = 20;
      bytes_queued   = 0;
      mismatches     = 0;

      // Directed text: ASCII extremes, null, stray continuation bytes.
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h7F, 1'b0);
      queue_byte(8'h80, 1'b0);
      queue_byte(8'hBF, 1'b0);
      // one complete character of each length
      queue_byte(8'hC2, 1'b0);
      queue_byte(8'hA9, 1'b0);
      queue_byte(8'hE2, 1'b0);
      queue_byte(8'h82, 1'b0);
      queue_byte(8'hAC, 1'b0);
      queue_byte(8'hF0, 1'b0);
      queue_byte(8'h9F, 1'b0);
      queue_byte(8'h98, 1'b0);
      queue_byte(8'h80, 1'b0);
      // oversized lead with all-ones continuations: largest code point
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'hFF, 1'b0);
      // text ends inside a 3-byte sequence
      queue_byte(8'hE2, 1'b0);
      queue_byte(8'h82, 1'b1);
      // a lead byte alone as the whole text, 4-byte and 2-byte
      queue_byte(8'hF4, 1'b1);
      queue_byte(8'hC0, 1'b1);
      // null byte ends a text
      queue_byte(8'h00, 1'b1);
      // oversized lead cut after two continuations
      queue_byte(8'hF8, 1'b0);
      queue_byte(8'h80, 1'b0);
      queue_byte(8'h80, 1'b1);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      wait_for_drain();

      // Random texts in phases of differing pressure; each phase drains
      // fully before the next, and the last runs with no idling at all.
      run_phase(30, 30, 500);
      run_phase(0, 0, 800);
      run_phase(10, 60, 1250);
      run_phase(60, 10, 1650);
      run_phase(0, 0, 1950);

      // Let the pipeline settle so any spurious late beat is caught.
      repeat (8) @(negedge clock);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/u2c_pkg.sv
rtl/u2c_stream_if.sv
rtl/u2c_input_stage.sv
rtl/u2c_decode.sv
rtl/utf8_to_codepoint_utf16_offset_core.sv
bench/testbench.sv
